>>> sv/wstd_pkg.sv
// Shared types, codes and default sizes of the work-stealing task dispatcher.
package wstd_pkg;

  // Default sizes handed to the top level.
  localparam int WORKERS_DEF     = 4;
  localparam int TASKS_DEF       = 16;
  localparam int STACK_DEPTH_DEF = 16;

  // Fixed field widths of the stream beats.
  localparam int OP_W      = 2;
  localparam int WORKER_W  = 2;
  localparam int TASK_W    = 4;
  localparam int SRC_W     = 2;
  localparam int OUT_CNT_W = 5;
  localparam int S_DATA_W  = 8;
  localparam int M_DATA_W  = 16;

  typedef enum logic [OP_W-1:0] {
    OP_INJECT = 2'd0,
    OP_FETCH  = 2'd1,
    OP_PARK   = 2'd2,
    OP_FINISH = 2'd3
  } op_t;

  typedef enum logic [SRC_W-1:0] {
    SRC_OWN      = 2'd0,
    SRC_STOLEN   = 2'd1,
    SRC_INJECTOR = 2'd2,
    SRC_NONE     = 2'd3
  } src_t;

  // One result beat, last field in the lowest bits.
  typedef struct packed {
    logic                 all_done;
    logic [OUT_CNT_W-1:0] outstanding;
    logic                 dropped;
    src_t                 source;
    logic                 got_task;
    logic [TASK_W-1:0]    given_task;
  } result_t;

  localparam int RES_W = $bits(result_t);

endpackage

>>> sv/work_stealing_task_dispatcher_core.sv
// Top level of the work-stealing task dispatcher.
//
//  Channel  Direction  Beat contents (lowest bit first)
//  s_*      in         op[1:0], worker[3:2], task_id[7:4]
//  m_*      out        given_task[3:0], got_task[4], source[6:5], dropped[7],
//                      outstanding[12:8], all_done[13], zero[15:14]
//
// For each request, the stack heights are decided and the slot RAM is written
// or read in the accept cycle, and the registered RAM read data forms the
// result in the next cycle. Requests are handled one at a time.
// A stalled result beat parks the pending result and holds off new requests
// until it drains. Reset (rst, synchronous) empties all stacks at once
// through their heights and clears the outstanding count.
module work_stealing_task_dispatcher_core #(
  parameter int WORKERS     = wstd_pkg::WORKERS_DEF,
  parameter int TASKS       = wstd_pkg::TASKS_DEF,
  parameter int STACK_DEPTH = wstd_pkg::STACK_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // op[1:0], worker[3:2], task_id[7:4]
  input  logic [wstd_pkg::S_DATA_W-1:0] s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // given_task[3:0], got_task[4], source[6:5], dropped[7], outstanding[12:8],
  // all_done[13], zero fill[15:14]
  output logic [wstd_pkg::M_DATA_W-1:0] m_tdata
);

  import wstd_pkg::*;

  localparam int SW      = $clog2(WORKERS + 1);
  localparam int HW      = $clog2(STACK_DEPTH + 1);
  localparam int CW      = $clog2(TASKS + 1);
  localparam int ENTRIES = (WORKERS + 1) * STACK_DEPTH;
  localparam int AW      = $clog2(ENTRIES);
  localparam int INJ     = WORKERS;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RESP,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic                 got;
    src_t                 source;
    logic                 dropped;
    logic [OUT_CNT_W-1:0] outstanding;
    logic                 all_done;
  } pend_t;

  state_t            state;
  logic [HW-1:0]     height [WORKERS+1];
  logic [CW-1:0]     cnt;
  logic [CW-1:0]     cnt_next;
  pend_t             pend;
  pend_t             pend_next;
  result_t           res;
  result_t           fresh;
  logic [TASK_W-1:0] given_hold;

  op_t               in_op;
  logic [TASK_W-1:0] in_task;
  logic [SW-1:0]     wk;
  logic              w_ok;
  logic [WORKERS:0]  nonempty;
  logic              steal_found;
  logic [SW-1:0]     steal_idx;
  logic [SW-1:0]     sidx;
  logic [HW-1:0]     sel_h;
  logic              full;
  logic              push_req;
  logic              force_drop;
  logic              do_push;
  logic              do_pop;
  src_t              src;
  logic [HW-1:0]     slot;
  logic [AW-1:0]     mem_addr;
  logic              mem_we;
  logic [TASK_W-1:0] mem_rdata;
  logic              accept;
  logic              out_free;
  logic              load_res;

  // Unpack the request beat.
  assign in_op   = op_t'(s_tdata[OP_W-1:0]);
  assign wk      = SW'(s_tdata[OP_W+WORKER_W-1:OP_W]);
  assign in_task = s_tdata[OP_W+WORKER_W+TASK_W-1:OP_W+WORKER_W];
  assign w_ok    = wk < SW'(WORKERS);

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign load_res = ((state == ST_RESP) || (state == ST_HOLD)) && out_free;

  // Per-stack occupancy and the lowest-numbered sibling to steal from.
  always_comb begin
    steal_found = 1'b0;
    steal_idx   = '0;
    for (int v = 0; v <= WORKERS; v++) begin
      nonempty[v] = (height[v] != '0);
    end
    for (int v = WORKERS - 1; v >= 0; v--) begin
      if (nonempty[v] && (SW'(v) != wk)) begin
        steal_found = 1'b1;
        steal_idx   = SW'(v);
      end
    end
  end

  // Choose the target stack and the kind of access.
  always_comb begin
    sidx       = SW'(INJ);
    push_req   = 1'b0;
    force_drop = 1'b0;
    do_pop     = 1'b0;
    src        = SRC_NONE;
    unique case (in_op)
      OP_INJECT: begin
        push_req = 1'b1;
      end
      OP_FETCH: begin
        if (w_ok && nonempty[wk]) begin
          sidx   = wk;
          do_pop = 1'b1;
          src    = SRC_OWN;
        end else if (w_ok && steal_found) begin
          sidx   = steal_idx;
          do_pop = 1'b1;
          src    = SRC_STOLEN;
        end else if (w_ok && nonempty[INJ]) begin
          do_pop = 1'b1;
          src    = SRC_INJECTOR;
        end
      end
      OP_PARK: begin
        if (w_ok) begin
          sidx     = wk;
          push_req = 1'b1;
        end else begin
          force_drop = 1'b1;
        end
      end
      OP_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  // Stack top address and the count after this request.
  always_comb begin
    sel_h    = height[sidx];
    full     = (sel_h == HW'(STACK_DEPTH));
    do_push  = push_req && !full;
    slot     = do_pop ? sel_h - 1'b1 : sel_h;
    mem_addr = AW'(AW'(sidx) * AW'(STACK_DEPTH) + AW'(slot));
    mem_we   = accept && do_push;

    cnt_next = cnt;
    if ((in_op == OP_INJECT) && do_push && (cnt < CW'(TASKS))) begin
      cnt_next = cnt + 1'b1;
    end else if ((in_op == OP_FINISH) && (cnt != '0)) begin
      cnt_next = cnt - 1'b1;
    end

    pend_next.got         = do_pop;
    pend_next.source      = src;
    pend_next.dropped     = force_drop || (push_req && full);
    pend_next.outstanding = OUT_CNT_W'(cnt_next);
    pend_next.all_done    = (cnt_next == '0);
  end

  wstd_stack_ram #(
    .DEPTH (ENTRIES),
    .DW    (TASK_W),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (in_task),
    .rdata (mem_rdata)
  );

  // Result assembled from the pending fields and the slot read data.
  // While parked, the task id comes from the copy taken when the RAM data was fresh.
  always_comb begin
    fresh.given_task  = (state == ST_HOLD) ? given_hold :
                        (pend.got ? mem_rdata : '0);
    fresh.got_task    = pend.got;
    fresh.source      = pend.source;
    fresh.dropped     = pend.dropped;
    fresh.outstanding = pend.outstanding;
    fresh.all_done    = pend.all_done;
  end

  assign m_tdata = M_DATA_W'(res);

  // Sequencer, stack heights, count and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      cnt      <= '0;
      for (int v = 0; v <= WORKERS; v++) begin
        height[v] <= '0;
      end
    end else begin
      // The result register loads once a result is ready and the port is free.
      if (load_res) begin
        res      <= fresh;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            if (do_pop) begin
              height[sidx] <= sel_h - 1'b1;
            end else if (do_push) begin
              height[sidx] <= sel_h + 1'b1;
            end
            cnt   <= cnt_next;
            pend  <= pend_next;
            state <= ST_RESP;
          end
        end
        ST_RESP: begin
          given_hold <= fresh.given_task;
          if (out_free) begin
            state <= ST_IDLE;
          end else begin
            state <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> sv/wstd_stack_ram.sv
// Single-port synchronous RAM that holds the task slots of all stacks.
module wstd_stack_ram #(
  parameter int DEPTH = 80,
  parameter int DW    = 4,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // Write on request, registered read every cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> sv/wstd_checker.sv
// Port-level checks of the dispatcher and their binding to the top level.
module wstd_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [wstd_pkg::M_DATA_W-1:0] m_tdata
);

  import wstd_pkg::*;

  result_t res;

  assign res = result_t'(m_tdata[RES_W-1:0]);

  // A found task always names where it came from and never reports a drop.
  a_got_src: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res.got_task |-> (res.source != SRC_NONE) && !res.dropped)
    else $error("found task without a source or with a drop");

  // Nothing found means no source and a zero task id.
  a_none: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !res.got_task |-> (res.source == SRC_NONE) && (res.given_task == '0))
    else $error("empty result carries a source or a task id");

  // The done flag only shows with a zero outstanding count.
  a_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res.all_done |-> (res.outstanding == '0))
    else $error("all_done with tasks outstanding");

  // One request in flight: an accepted beat closes the input in the next cycle.
  a_one_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second request taken while one is in flight");

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

endmodule

bind work_stealing_task_dispatcher_core wstd_checker u_wstd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
